// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for RTL that checks its own logic; included by dot_star_regex_matcher.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/dsm_pkg.sv -----
// Shared types and constants for the dot-star pattern matcher.
`timescale 1ns / 1ps

package dsm_pkg;

  localparam int DSM_MAX_TOKENS = 32;

  localparam logic [7:0] STAR_BYTE = 8'd42;
  localparam logic [7:0] DOT_BYTE  = 8'd46;

  typedef enum logic [1:0] {
    KIND_PATTERN    = 2'd0,
    KIND_TEXT       = 2'd1,
    KIND_EMPTY_PAT  = 2'd2,
    KIND_EMPTY_TEXT = 2'd3
  } kind_t;

  // Broadcast to every cell in the row
  typedef struct packed {
    logic       fresh;  // text starts from the start set, not the stored set
    logic       step;   // a text byte is accepted this cycle
    logic [7:0] sym;
  } cell_ctl_t;

  // Token write, steered to one cell by its select line
  typedef struct packed {
    logic       byte_we;
    logic       star;
    logic [7:0] data;
  } tok_wr_t;

endpackage

// ----- hw/rtl/dsm_cell.sv -----
// One NFA cell: a pattern token and the active bit of its position.
`timescale 1ns / 1ps

module dsm_cell (
  input  logic              clk,
  input  dsm_pkg::cell_ctl_t ctl,
  input  dsm_pkg::tok_wr_t  wr,
  input  logic              wr_sel,
  input  logic              used,
  input  logic              start,
  input  logic              shift_in,
  input  logic              clos_in,
  output logic              shift_out,
  output logic              clos_out,
  output logic              act
);
  import dsm_pkg::*;

  logic [7:0] tok_byte;
  logic       tok_star;
  logic       act_q;
  logic       prev;
  logic       hit;

  always_ff @(posedge clk) begin
    if (wr_sel) begin
      if (wr.byte_we) begin
        tok_byte <= wr.data;
      end
      tok_star <= wr.star;
    end
    if (ctl.step) begin
      act_q <= act;
    end
  end

  always_comb begin
    prev      = ctl.fresh ? start : act_q;
    hit       = used && prev && (tok_byte == ctl.sym || tok_byte == DOT_BYTE);
    // a starred token stays put on a hit, a literal one hands the bit right
    act       = (hit && tok_star) || shift_in || clos_in;
    shift_out = hit && !tok_star;
    // skip over a starred token without consuming a byte
    clos_out  = act && tok_star && used;
  end

endmodule

// ----- hw/rtl/dot_star_regex_matcher.sv -----
// Top level of the dot-star pattern matcher: token loading, cell row and result register.
//
//  channel | dir | tdata          | tuser      | tlast
//  s_axis  | in  | [7:0] symbol   | [1:0] kind | is_last
//  m_axis  | out | [0] matched    | [0] status | -
//
// The row of cells updates all token positions at once and the longest path is the star
// closure rippling through the row.
// A result sits in the output register until taken; s_axis_tready drops only while that
// register is full and not being drained.
// Reset clears the pattern to empty; token storage is not cleared.
`timescale 1ns / 1ps

module dot_star_regex_matcher #(
  parameter int MAX_TOKENS = dsm_pkg::DSM_MAX_TOKENS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] symbol
  input  logic [1:0] s_axis_tuser,   // [1:0] kind
  input  logic       s_axis_tlast,   // is_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] matched, [7:1] zero
  output logic       m_axis_tuser    // [0] status
);
  import dsm_pkg::*;

  `include "assert_macros.svh"

  localparam int CW = $clog2(MAX_TOKENS + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_TOKENS);

  // pattern state
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] lead, lead_next;     // leading run of starred tokens
  logic          pend, pend_next;     // held byte sits in cell[count] as a literal
  logic          ovf, ovf_next;
  logic          open, open_next;
  logic          text_open, text_open_next;

  logic          out_valid;
  logic          out_matched;
  logic          out_status;

  logic          accept;
  logic          take;
  kind_t         kind;
  logic [7:0]    sym;

  // pattern closed as if its last byte had come
  logic          tent;
  logic [CW-1:0] count_f;
  logic          ovf_f;

  // temporaries of the pattern-byte path
  logic [CW-1:0] c0, c1, l0;
  logic          p0, p1, o1;

  logic          wr_en;
  logic [CW-1:0] wr_idx;
  tok_wr_t       wr;
  cell_ctl_t     ctl;

  logic          res_valid;
  logic          res_matched;

  logic [MAX_TOKENS:0]   act_vec;
  logic [MAX_TOKENS-1:0] shift_vec;
  logic [MAX_TOKENS-1:0] clos_vec;

  assign kind          = kind_t'(s_axis_tuser);
  assign sym           = s_axis_tdata;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign take          = out_valid && m_axis_tready;

  assign tent    = pend && (count < CAP);
  assign count_f = count + CW'(tent);
  assign ovf_f   = ovf || (pend && !tent);

  assign ctl.fresh = !text_open;
  assign ctl.step  = accept && (kind == KIND_TEXT);
  assign ctl.sym   = sym;

  // next pattern and text state
  always_comb begin
    count_next     = count;
    lead_next      = lead;
    pend_next      = pend;
    ovf_next       = ovf;
    open_next      = open;
    text_open_next = text_open;
    wr_en          = 1'b0;
    wr_idx         = '0;
    wr.byte_we     = 1'b0;
    wr.star        = 1'b0;
    wr.data        = sym;
    res_valid      = 1'b0;
    res_matched    = 1'b0;
    c0 = open ? count : '0;
    l0 = open ? lead : '0;
    p0 = open && pend;
    c1 = c0;
    p1 = p0;
    o1 = open && ovf;
    if (accept) begin
      unique case (kind)
        KIND_PATTERN: begin
          text_open_next = 1'b0;
          lead_next      = l0;
          if (p0 && sym == STAR_BYTE) begin
            // mark the held token starred
            if (c0 < CAP) begin
              wr_en   = 1'b1;
              wr_idx  = c0;
              wr.star = 1'b1;
              c1      = c0 + CW'(1);
              if (l0 == c0) begin
                lead_next = l0 + CW'(1);
              end
            end else begin
              o1 = 1'b1;
            end
            p1 = 1'b0;
          end else begin
            if (p0) begin
              if (c0 < CAP) begin
                c1 = c0 + CW'(1);
              end else begin
                o1 = 1'b1;
              end
            end
            // hold the new byte as a tentative literal
            if (c1 < CAP) begin
              wr_en      = 1'b1;
              wr_idx     = c1;
              wr.byte_we = 1'b1;
            end
            p1 = 1'b1;
          end
          count_next = c1;
          ovf_next   = o1;
          pend_next  = p1;
          open_next  = 1'b1;
          if (s_axis_tlast) begin
            open_next = 1'b0;
            pend_next = 1'b0;
            if (p1) begin
              if (c1 < CAP) begin
                count_next = c1 + CW'(1);
              end else begin
                ovf_next = 1'b1;
              end
            end
          end
        end
        KIND_EMPTY_PAT: begin
          count_next     = '0;
          lead_next      = '0;
          pend_next      = 1'b0;
          ovf_next       = 1'b0;
          open_next      = 1'b0;
          text_open_next = 1'b0;
        end
        KIND_EMPTY_TEXT: begin
          count_next     = count_f;
          ovf_next       = ovf_f;
          pend_next      = 1'b0;
          open_next      = 1'b0;
          text_open_next = 1'b0;
          res_valid      = 1'b1;
          res_matched    = !ovf_f && (count_f == lead);
        end
        KIND_TEXT: begin
          count_next     = count_f;
          ovf_next       = ovf_f;
          pend_next      = 1'b0;
          open_next      = 1'b0;
          text_open_next = !s_axis_tlast;
          res_valid      = s_axis_tlast;
          res_matched    = !ovf_f && act_vec[count_f];
        end
        default: begin
          count_next = count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      lead      <= '0;
      pend      <= 1'b0;
      ovf       <= 1'b0;
      open      <= 1'b0;
      text_open <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      count     <= count_next;
      lead      <= lead_next;
      pend      <= pend_next;
      ovf       <= ovf_next;
      open      <= open_next;
      text_open <= text_open_next;
      if (res_valid) begin
        out_valid <= 1'b1;
      end else if (take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_matched <= res_matched;
      out_status  <= ovf_f;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_matched};
  assign m_axis_tuser  = out_status;

  // row of cells, one per token position
  genvar k;
  generate
    for (k = 0; k < MAX_TOKENS; k++) begin : g_cell
      logic sel;
      logic used;
      logic start;
      logic sh_in;
      logic cl_in;

      assign sel   = wr_en && (wr_idx == CW'(k));
      assign used  = CW'(k) < count_f;
      assign start = CW'(k) <= lead;

      if (k == 0) begin : g_head
        assign sh_in = 1'b0;
        assign cl_in = 1'b0;
      end else begin : g_link
        assign sh_in = shift_vec[k-1];
        assign cl_in = clos_vec[k-1];
      end

      dsm_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .wr        (wr),
        .wr_sel    (sel),
        .used      (used),
        .start     (start),
        .shift_in  (sh_in),
        .clos_in   (cl_in),
        .shift_out (shift_vec[k]),
        .clos_out  (clos_vec[k]),
        .act       (act_vec[k])
      );
    end
  endgenerate

  // final position has no token: it only collects from the last cell
  assign act_vec[MAX_TOKENS] = shift_vec[MAX_TOKENS-1] || clos_vec[MAX_TOKENS-1];

  `ASSERT_CLK(a_pend_needs_open, clk, rst, pend |-> open, "held byte without open pattern")
  `ASSERT_CLK(a_lead_in_count, clk, rst, lead <= count, "star run longer than pattern")
  `ASSERT_CLK(a_count_cap, clk, rst, count <= CAP, "token count above capacity")
  `ASSERT_CLK(a_query_result, clk, rst,
              accept && kind == KIND_EMPTY_TEXT |=> out_valid, "empty text query lost")
  `ASSERT_ALWAYS(a_reset_clears, clk, $past(rst) |-> !out_valid && !open, "state after reset")

endmodule
